>>> src/bbc_pkg.sv
package bbc_pkg;

  localparam int unsigned SlotsDefault = 32;
  localparam int unsigned SlotOutW     = 5;
  localparam int unsigned DevW         = 16;
  localparam int unsigned BlkW         = 32;
  localparam int unsigned CntW         = 8;
  localparam int unsigned TimeW        = 32;

  typedef enum logic [1:0] {
    KIND_GET     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_PIN     = 2'd2,
    KIND_UNPIN   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_MISS      = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [DevW-1:0]      device;
    logic [BlkW-1:0]      block_number;
    logic [SlotOutW-1:0]  slot_in;
    logic [TimeW-1:0]     now;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [SlotOutW-1:0]  slot_out;
    logic                 needs_fill;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_GET_WB,
    S_SLOT_RD,
    S_SLOT_WB,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_scan;
    logic rd_slot;
    logic wb_get;
    logic wb_slot;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e in_kind;
    logic  in_slot_ok;
    logic  scan_last;
    logic  out_free;
  } ctrl_sts_t;

endpackage

>>> src/bbc_ctrl.sv
module bbc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bbc_pkg::ctrl_sts_t  sts_i,
  output bbc_pkg::ctrl_cmd_t  cmd_o
);
  import bbc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_kind == KIND_GET) begin
            state_d = S_SCAN;
          end else if (sts_i.in_slot_ok) begin
            state_d = S_SLOT_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: state_d = S_GET_WB;
      S_GET_WB:   state_d = S_DONE;
      S_SLOT_RD:  state_d = S_SLOT_WB;
      S_SLOT_WB:  state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_SCAN:     cmd_o.rd_scan = 1'b1;
      S_SCAN_END: cmd_o = '0;
      S_GET_WB:   cmd_o.wb_get = 1'b1;
      S_SLOT_RD:  cmd_o.rd_slot = 1'b1;
      S_SLOT_WB:  cmd_o.wb_slot = 1'b1;
      S_DONE:     cmd_o.out_load = sts_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

endmodule

>>> src/bbc_dp.sv
module bbc_dp #(
  parameter int unsigned SLOTS = bbc_pkg::SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbc_pkg::req_t       in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output bbc_pkg::rsp_t       out_data_o,
  input  bbc_pkg::ctrl_cmd_t  cmd_i,
  output bbc_pkg::ctrl_sts_t  sts_o
);
  import bbc_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic [DevW-1:0]  dev;
    logic [BlkW-1:0]  blk;
    logic [CntW-1:0]  cnt;
    logic [TimeW-1:0] last;
  } row_t;

  localparam logic [CntW-1:0] CntMax = '1;

  row_t mem [SLOTS];

  // An entry never written reads as all zero.
  logic [SLOTS-1:0] init_q;
  logic [SLOTS-1:0] cvalid_q;

  req_t            req_q;
  logic [IdxW-1:0] ptr_q;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  row_t            rd_row_q;
  logic            rd_init_q;
  logic            rd_cv_q;

  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [CntW-1:0] hit_cnt_q;
  logic            best_q;
  logic [IdxW-1:0] best_idx_q;
  logic [TimeW-1:0] best_last_q;

  logic            out_valid_q;
  rsp_t            out_data_q;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] slot_idx;
  logic            slot_ok;
  row_t            eff_row;
  logic            is_match;
  logic            is_older;

  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  row_t            wr_row;
  logic            wr_set_cv;
  rsp_t            rsp;

  assign slot_idx = IdxW'(req_q.slot_in);
  assign slot_ok  = 32'(req_q.slot_in) < SLOTS;

  assign rd_en   = cmd_i.rd_scan | cmd_i.rd_slot;
  assign rd_addr = cmd_i.rd_slot ? slot_idx : ptr_q;

  assign eff_row  = rd_init_q ? rd_row_q : '0;
  assign is_match = rd_cv_q && (eff_row.dev == req_q.device)
                    && (eff_row.blk == req_q.block_number);
  assign is_older = (eff_row.cnt == '0) && (!best_q || (eff_row.last < best_last_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (rd_en) begin
      rd_row_q  <= mem[rd_addr];
      rd_init_q <= init_q[rd_addr];
      rd_cv_q   <= cvalid_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (out_valid_o == 1'b0 || !out_stall_i) begin
      if (cmd_i.out_load) begin
        out_data_q <= rsp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      cvalid_q    <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_cnt_q   <= '0;
      best_q      <= 1'b0;
      best_idx_q  <= '0;
      best_last_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_scan;
      if (cmd_i.load) begin
        ptr_q  <= '0;
        hit_q  <= 1'b0;
        best_q <= 1'b0;
      end else if (cmd_i.rd_scan) begin
        ptr_q <= ptr_q + 1'b1;
      end
      // Scan data arrives in the cycle after its read; the lowest match wins.
      if (rd_vld_q) begin
        if (is_match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= rd_idx_q;
          hit_cnt_q <= eff_row.cnt;
        end
        if (is_older) begin
          best_q      <= 1'b1;
          best_idx_q  <= rd_idx_q;
          best_last_q <= eff_row.last;
        end
      end
      if (wr_en) begin
        init_q[wr_addr] <= 1'b1;
        if (wr_set_cv) begin
          cvalid_q[wr_addr] <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = slot_idx;
    wr_row    = eff_row;
    wr_set_cv = 1'b0;
    if (cmd_i.wb_get) begin
      if (hit_q) begin
        wr_en       = 1'b1;
        wr_addr     = hit_idx_q;
        wr_row.dev  = req_q.device;
        wr_row.blk  = req_q.block_number;
        wr_row.cnt  = (hit_cnt_q == CntMax) ? hit_cnt_q : hit_cnt_q + 1'b1;
        wr_row.last = req_q.now;
      end else if (best_q) begin
        wr_en       = 1'b1;
        wr_set_cv   = 1'b1;
        wr_addr     = best_idx_q;
        wr_row.dev  = req_q.device;
        wr_row.blk  = req_q.block_number;
        wr_row.cnt  = CntW'(1);
        wr_row.last = best_last_q;
      end
    end else if (cmd_i.wb_slot) begin
      if (req_q.kind == KIND_PIN) begin
        wr_en      = 1'b1;
        wr_row.cnt = (eff_row.cnt == CntMax) ? eff_row.cnt : eff_row.cnt + 1'b1;
      end else if (eff_row.cnt != '0) begin
        wr_en      = 1'b1;
        wr_row.cnt = eff_row.cnt - 1'b1;
        if (req_q.kind == KIND_RELEASE) begin
          wr_row.last = req_q.now;
        end
      end
    end
  end

  always_comb begin
    rsp            = '0;
    rsp.status     = ST_DONE;
    rsp.slot_out   = req_q.slot_in;
    rsp.needs_fill = 1'b0;
    if (req_q.kind == KIND_GET) begin
      if (hit_q) begin
        rsp.slot_out = SlotOutW'(hit_idx_q);
      end else if (best_q) begin
        rsp.status     = ST_MISS;
        rsp.slot_out   = SlotOutW'(best_idx_q);
        rsp.needs_fill = 1'b1;
      end else begin
        rsp.status   = ST_FULL;
        rsp.slot_out = '0;
      end
    end else if (slot_ok && req_q.kind != KIND_PIN && eff_row.cnt == '0) begin
      rsp.status = ST_UNDERFLOW;
    end
  end

  assign sts_o.in_kind    = in_data_i.kind;
  assign sts_o.in_slot_ok = 32'(in_data_i.slot_in) < SLOTS;
  assign sts_o.scan_last  = (ptr_q == IdxW'(SLOTS - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> src/block_buffer_cache_lru.sv
// Buffer-slot tag cache with reference counts and oldest-first replacement.
// One request is in flight at a time. A get reads every slot of the tag
// memory in turn through its single read port, then writes the hit or the
// claimed slot back, if there is one. Release, pin and unpin do one
// read-modify-write of the named slot; one aimed at a slot beyond the table
// goes straight to its result. Results sit in an output register, so a
// stalled result holds up the next request only while that register is
// still full.
module block_buffer_cache_lru #(
  parameter int unsigned SLOTS = bbc_pkg::SlotsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bbc_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bbc_pkg::rsp_t  out_data_o
);
  import bbc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> tb/block_buffer_cache_lru_checker.sv
`timescale 1ns / 100ps

module block_buffer_cache_lru_checker
  import bbc_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  req_t in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  rsp_t out_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   hits_o,
  output int   misses_o,
  output int   full_o,
  output int   underflow_o,
  output int   saturated_o
);

  // Shadow copy of the tag table.
  logic [DevW-1:0]  tag_dev [SLOTS];
  logic [BlkW-1:0]  tag_blk [SLOTS];
  logic [CntW-1:0]  refs    [SLOTS];
  logic [TimeW-1:0] stamp   [SLOTS];
  logic             filled  [SLOTS];

  rsp_t replies_due[$];

  // Applies one request to the shadow table and works out the reply it earns.
  task automatic run_cache_op(input req_t r, output rsp_t e);
    int hit;
    int victim;
    hit = -1;
    victim = -1;
    e = '{status: ST_DONE, slot_out: r.slot_in, needs_fill: 1'b0};
    if (r.kind == KIND_GET) begin
      e.slot_out = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && filled[i] && tag_dev[i] == r.device && tag_blk[i] == r.block_number) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        if (refs[hit] == '1) begin
          saturated_o++;
        end else begin
          refs[hit]++;
        end
        stamp[hit] = r.now;
        e.slot_out = SlotOutW'(hit);
        hits_o++;
      end else begin
        // Oldest unreferenced slot; the strict compare keeps the lowest on a tie.
        for (int i = 0; i < SLOTS; i++) begin
          if (refs[i] == '0 && (victim < 0 || stamp[i] < stamp[victim])) begin
            victim = i;
          end
        end
        if (victim < 0) begin
          e.status = ST_FULL;
          full_o++;
        end else begin
          tag_dev[victim] = r.device;
          tag_blk[victim] = r.block_number;
          refs[victim]    = CntW'(1);
          filled[victim]  = 1'b1;
          e.status        = ST_MISS;
          e.slot_out      = SlotOutW'(victim);
          e.needs_fill    = 1'b1;
          misses_o++;
        end
      end
    end else if (int'(r.slot_in) < SLOTS) begin
      if (r.kind == KIND_PIN) begin
        if (refs[r.slot_in] == '1) begin
          saturated_o++;
        end else begin
          refs[r.slot_in]++;
        end
      end else if (refs[r.slot_in] == '0) begin
        e.status = ST_UNDERFLOW;
        underflow_o++;
      end else begin
        refs[r.slot_in]--;
        if (r.kind == KIND_RELEASE) begin
          stamp[r.slot_in] = r.now;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t want;
    rsp_t got;
    logic bad;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        refs[i]    = '0;
        stamp[i]   = '0;
        filled[i]  = 1'b0;
      end
      replies_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
      hits_o       = 0;
      misses_o     = 0;
      full_o       = 0;
      underflow_o  = 0;
      saturated_o  = 0;
    end else begin
      // A reply never belongs to a request taken on the same edge, so pop first.
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (replies_due.size() == 0) begin
          $error("reply beat with no request outstanding: %p", got);
          fail_count_o++;
        end else begin
          want = replies_due.pop_front();
          bad  = 1'b0;
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            bad = 1'b1;
          end
          if (got.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
            bad = 1'b1;
          end
          if (got.needs_fill !== want.needs_fill) begin
            $error("needs_fill: expected %0d, actual %0d", want.needs_fill, got.needs_fill);
            bad = 1'b1;
          end
          if (bad) begin
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        run_cache_op(in_data_i, want);
        replies_due.push_back(want);
      end
      pending_o = replies_due.size();
    end
  end

endmodule

>>> tb/block_buffer_cache_lru_tb.sv
`timescale 1ns / 100ps

module block_buffer_cache_lru_tb;
  import bbc_pkg::*;

  localparam int RandomItems = 1300;
  localparam int PileDepth   = 258;

  typedef enum int {
    SEG_MIX,
    SEG_FILL,
    SEG_DRAIN
  } seg_e;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  int fails;
  int pending;
  int hits;
  int misses;
  int fulls;
  int underflows;
  int saturations;

  int          sent;
  logic        steady;
  logic [31:0] tick_count;

  always #5 clk = ~clk;

  block_buffer_cache_lru u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  block_buffer_cache_lru_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fails),
    .pending_o    (pending),
    .hits_o       (hits),
    .misses_o     (misses),
    .full_o       (fulls),
    .underflow_o  (underflows),
    .saturated_o  (saturations)
  );

  // Mostly a slowly rising tick, with repeats for ties and some wild values.
  function automatic logic [31:0] next_stamp();
    int roll;
    roll = $urandom_range(0, 99);
    tick_count += $urandom_range(0, 3);
    if (roll < 5) return $urandom;
    if (roll == 5) return '0;
    if (roll == 6) return '1;
    return tick_count;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic issue(input kind_e k, input logic [DevW-1:0] dev,
                       input logic [BlkW-1:0] blk, input logic [SlotOutW-1:0] slot,
                       input logic [TimeW-1:0] stamp_val);
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap  = 0;
    if (!steady) begin
      if (roll >= 95) begin
        gap = $urandom_range(8, 40);
      end else if (roll >= 65) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: k, device: dev, block_number: blk, slot_in: slot, now: stamp_val};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  initial begin : stimulus
    logic [DevW-1:0]     dev_pool [4];
    logic [BlkW-1:0]     blk_pool [12];
    logic [DevW-1:0]     dev;
    logic [BlkW-1:0]     blk;
    logic [SlotOutW-1:0] hot_slot;
    kind_e               k;
    seg_e                seg;
    int                  p_get;
    int                  p_rel;
    int                  p_pin;
    int                  p_fresh;
    int                  roll;
    logic                piled;
    logic                drained;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    sent       = 0;
    steady     = 1'b0;
    tick_count = '0;
    piled      = 1'b0;
    drained    = 1'b0;
    hot_slot   = '0;
    foreach (dev_pool[i]) dev_pool[i] = DevW'($urandom);
    foreach (blk_pool[i]) blk_pool[i] = $urandom;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Tags left at zero by reset are not valid, so this must miss.
    issue(KIND_GET, '0, '0, '0, '0);
    issue(KIND_GET, '1, '1, '1, '1);
    issue(KIND_GET, '0, '0, '1, 32'd5);
    // Partial tag matches are misses.
    issue(KIND_GET, '0, '1, '0, 32'd6);
    issue(KIND_GET, '1, '0, '0, 32'd7);
    issue(KIND_RELEASE, DevW'($urandom), $urandom, 5'd0, 32'd100);
    issue(KIND_RELEASE, DevW'($urandom), $urandom, 5'd0, 32'd200);
    issue(KIND_RELEASE, DevW'($urandom), $urandom, 5'd0, 32'd300);
    issue(KIND_UNPIN, DevW'($urandom), $urandom, 5'd0, 32'd301);
    issue(KIND_PIN, DevW'($urandom), $urandom, 5'd31, $urandom);
    issue(KIND_UNPIN, DevW'($urandom), $urandom, 5'd31, $urandom);
    issue(KIND_PIN, DevW'($urandom), $urandom, 5'd21, $urandom);
    issue(KIND_PIN, DevW'($urandom), $urandom, 5'd10, $urandom);
    // Several free slots share a zero stamp; the lowest must be taken.
    issue(KIND_GET, 16'h1234, 32'h5678_9abc, 5'd7, 32'd400);
    // A hit on a slot nobody holds.
    issue(KIND_GET, '0, '0, 5'd3, 32'd500);
    issue(KIND_UNPIN, DevW'($urandom), $urandom, 5'd1, 32'd600);
    issue(KIND_RELEASE, DevW'($urandom), $urandom, 5'd2, '1);
    issue(KIND_GET, 16'h8001, 32'h0000_0001, 5'd0, '0);
    issue(KIND_UNPIN, DevW'($urandom), $urandom, 5'd21, $urandom);
    issue(KIND_UNPIN, DevW'($urandom), $urandom, 5'd10, $urandom);

    while (sent < RandomItems + 20) begin
      steady = ($urandom_range(0, 4) == 0);
      if (!piled && sent >= 300) begin
        // Drive one slot's count into saturation, and later all the way back.
        hot_slot = SlotOutW'($urandom);
        repeat (PileDepth) issue(KIND_PIN, DevW'($urandom), $urandom, hot_slot, next_stamp());
        piled = 1'b1;
      end else if (!drained && sent >= 800) begin
        repeat (PileDepth) issue(KIND_UNPIN, DevW'($urandom), $urandom, hot_slot, next_stamp());
        drained = 1'b1;
      end else begin
        seg = seg_e'($urandom_range(0, 2));
        case (seg)
          SEG_FILL: begin
            p_get = 75; p_rel = 5;  p_pin = 15; p_fresh = 50;
          end
          SEG_DRAIN: begin
            p_get = 10; p_rel = 50; p_pin = 5;  p_fresh = 10;
          end
          default: begin
            p_get = 45; p_rel = 25; p_pin = 10; p_fresh = 15;
          end
        endcase
        repeat ($urandom_range(30, 100)) begin
          roll = $urandom_range(0, 99);
          if (roll < p_get) begin
            k = KIND_GET;
          end else if (roll < p_get + p_rel) begin
            k = KIND_RELEASE;
          end else if (roll < p_get + p_rel + p_pin) begin
            k = KIND_PIN;
          end else begin
            k = KIND_UNPIN;
          end
          if ($urandom_range(0, 99) < p_fresh) begin
            dev = DevW'($urandom);
            blk = $urandom;
          end else begin
            dev = dev_pool[$urandom_range(0, 3)];
            blk = blk_pool[$urandom_range(0, 11)];
          end
          issue(k, dev, blk, SlotOutW'($urandom), next_stamp());
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SlotsDefault + 10) @(posedge clk);
    $display("Sent %0d requests: %0d hits, %0d allocating misses, %0d with no free slot.",
             sent, hits, misses, fulls);
    $display("Saw %0d count underflows and %0d count saturations.", underflows, saturations);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : receiver
    int   run_left;
    int   cycles;
    int   roll;
    logic level;
    out_stall = 1'b0;
    run_left  = 0;
    cycles    = 0;
    level     = 1'b0;
    forever begin
      @(negedge clk);
      cycles++;
      if (cycles == 3000 || cycles == 15000) begin
        // Long hold so the output register fills and the input backs up.
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        cycles += 400;
        run_left = 0;
      end
      if (run_left == 0) begin
        roll = $urandom_range(0, 9);
        if (roll <= 5) begin
          level = 1'b0; run_left = $urandom_range(1, 8);
        end else if (roll <= 7) begin
          level = 1'b1; run_left = $urandom_range(1, 4);
        end else if (roll == 8) begin
          level = 1'b1; run_left = $urandom_range(10, 40);
        end else begin
          level = 1'b0; run_left = $urandom_range(50, 200);
        end
      end
      out_stall <= level;
      run_left--;
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
